@@ hw/rtl/mcwdg_pkg.sv @@
`default_nettype none

package mcwdg_pkg;

    // field widths
    localparam int MODE_W    = 2;
    localparam int ID_W      = 5;
    localparam int TMO_W     = 16;
    localparam int STATUS_W  = 2;
    localparam int COUNTER_W = 12;

    // item modes
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CREATE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_KICK   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_INIT   = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_TIMEOUT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TABLE_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_ID      = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ID_W-1:0]   client_id;
        logic [TMO_W-1:0]  req_timeout;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [ID_W-1:0]      new_id;
        logic                 reloaded;
        logic                 expired;
        logic                 reset_by_watchdog;
        logic [COUNTER_W-1:0] counter_value;
    } t_out_item;

endpackage

`default_nettype wire

@@ hw/rtl/mcwdg_core.sv @@
`default_nettype none

module mcwdg_core #(
    parameter int MAX_CLIENTS   = 31,
    parameter int RELOAD_MAX    = 4095,
    parameter int MS_PER_COUNT  = 6,
    parameter int PRESCALE_LOG2 = 8
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_fire,
    input  mcwdg_pkg::t_in_item    i_item,
    output mcwdg_pkg::t_out_item   o_result
);

    localparam int TMO_W     = mcwdg_pkg::TMO_W;
    localparam int ID_W      = mcwdg_pkg::ID_W;
    localparam int COUNTER_W = mcwdg_pkg::COUNTER_W;

    // reciprocal multiply for timeout / MS_PER_COUNT, exact over the timeout range
    localparam int DIV_SHIFT = TMO_W + $clog2(MS_PER_COUNT);
    localparam int MULT_W    = DIV_SHIFT + 1;
    localparam int DIV_MULT  = ((1 << DIV_SHIFT) + MS_PER_COUNT - 1) / MS_PER_COUNT;
    localparam int PROD_W    = TMO_W + MULT_W;

    logic [MAX_CLIENTS-1:0]   r_mask,     n_mask;
    logic [ID_W-1:0]          r_count,    n_count;
    logic [TMO_W-1:0]         r_gtimeout, n_gtimeout;
    logic [COUNTER_W-1:0]     r_reload,   n_reload;
    logic [COUNTER_W-1:0]     r_counter,  n_counter;
    logic [PRESCALE_LOG2-1:0] r_presc,    n_presc;
    logic                     r_running,  n_running;
    logic                     r_seen,     n_seen;

    logic [PROD_W-1:0]        product;
    logic [TMO_W-1:0]         quotient;
    logic [COUNTER_W-1:0]     reload_calc;
    logic [MAX_CLIENTS-1:0]   live_mask;
    logic [MAX_CLIENTS-1:0]   new_bit;
    logic [MAX_CLIENTS-1:0]   kick_bit;
    logic [MAX_CLIENTS-1:0]   kicked_mask;
    logic [PRESCALE_LOG2-1:0] presc_inc;

    // reload value for a create
    assign product  = PROD_W'(i_item.req_timeout) * PROD_W'(MULT_W'(DIV_MULT));
    assign quotient = product[DIV_SHIFT +: TMO_W];
    assign reload_calc = (quotient > TMO_W'(RELOAD_MAX)) ? COUNTER_W'(RELOAD_MAX)
                                                          : quotient[COUNTER_W-1:0];

    // client masks: created clients, next free slot, kicked slot
    always_comb begin
        for (int i = 0; i < MAX_CLIENTS; i++) begin
            live_mask[i] = (ID_W'(i) < r_count);
            new_bit[i]   = (ID_W'(i) == r_count);
            kick_bit[i]  = (ID_W'(i) == i_item.client_id);
        end
    end

    assign kicked_mask = r_mask | kick_bit;
    assign presc_inc   = r_presc + PRESCALE_LOG2'(1);

    // next state and result for the item in the input register
    always_comb begin
        n_mask     = r_mask;
        n_count    = r_count;
        n_gtimeout = r_gtimeout;
        n_reload   = r_reload;
        n_counter  = r_counter;
        n_presc    = r_presc;
        n_running  = r_running;
        n_seen     = r_seen;
        o_result   = '0;

        unique case (i_item.mode)
            mcwdg_pkg::MODE_TICK: begin
                if (r_running) begin
                    n_presc = presc_inc;
                    if (presc_inc == '0) begin
                        if (r_counter <= COUNTER_W'(1)) begin
                            n_counter        = '0;
                            n_seen           = 1'b1;
                            n_running        = 1'b0;
                            o_result.expired = 1'b1;
                        end else begin
                            n_counter = r_counter - COUNTER_W'(1);
                        end
                    end
                end
            end
            mcwdg_pkg::MODE_CREATE: begin
                if (i_item.req_timeout == '0) begin
                    o_result.status = mcwdg_pkg::STATUS_BAD_TIMEOUT;
                end else if (r_count >= ID_W'(MAX_CLIENTS)) begin
                    o_result.status = mcwdg_pkg::STATUS_TABLE_FULL;
                end else begin
                    o_result.new_id = r_count;
                    n_mask          = r_mask | new_bit;
                    n_count         = r_count + ID_W'(1);
                    if (i_item.req_timeout > r_gtimeout) begin
                        n_reload          = reload_calc;
                        n_counter         = reload_calc;
                        n_gtimeout        = i_item.req_timeout;
                        n_running         = 1'b1;
                        o_result.reloaded = 1'b1;
                    end
                end
            end
            mcwdg_pkg::MODE_KICK: begin
                if (i_item.client_id >= r_count) begin
                    o_result.status = mcwdg_pkg::STATUS_BAD_ID;
                end else if ((kicked_mask & live_mask) == live_mask) begin
                    n_counter         = r_reload;
                    n_mask            = '0;
                    o_result.reloaded = 1'b1;
                end else begin
                    n_mask = kicked_mask;
                end
            end
            mcwdg_pkg::MODE_INIT: begin
                o_result.reset_by_watchdog = r_seen;
                n_seen  = 1'b0;
                n_mask  = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase

        o_result.counter_value = n_counter;
    end

    // state registers, updated once per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask     <= '0;
            r_count    <= '0;
            r_gtimeout <= '0;
            r_reload   <= COUNTER_W'(RELOAD_MAX);
            r_counter  <= COUNTER_W'(RELOAD_MAX);
            r_presc    <= '0;
            r_running  <= 1'b0;
            r_seen     <= 1'b0;
        end else if (i_fire) begin
            r_mask     <= n_mask;
            r_count    <= n_count;
            r_gtimeout <= n_gtimeout;
            r_reload   <= n_reload;
            r_counter  <= n_counter;
            r_presc    <= n_presc;
            r_running  <= n_running;
            r_seen     <= n_seen;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/multi_client_watchdog.sv @@
`default_nettype none

// Multi-client watchdog. Every input transaction (tick, create, kick or init)
// gives exactly one result transaction. An item is taken into an input
// register, evaluated combinationally against the watchdog state and
// written to an output register; one item is accepted every cycle while
// the output side does not stall. A stall on the output holds the result
// register and, through it, the input register.

module multi_client_watchdog #(
    parameter int MAX_CLIENTS   = 31,
    parameter int RELOAD_MAX    = 4095,
    parameter int MS_PER_COUNT  = 6,
    parameter int PRESCALE_LOG2 = 8
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  mcwdg_pkg::t_in_item    i_in_data,
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output mcwdg_pkg::t_out_item   o_out_data
);

    logic                 r_in_valid;
    mcwdg_pkg::t_in_item  r_in;
    logic                 r_out_valid;
    mcwdg_pkg::t_out_item r_out;
    mcwdg_pkg::t_out_item result;
    logic                 out_free;
    logic                 fire;

    // the item in the input register moves on when the result register is free
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    mcwdg_core #(
        .MAX_CLIENTS   (MAX_CLIENTS),
        .RELOAD_MAX    (RELOAD_MAX),
        .MS_PER_COUNT  (MS_PER_COUNT),
        .PRESCALE_LOG2 (PRESCALE_LOG2)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .o_result (result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

@@ hw/rtl/mcwdg_checker.sv @@
`default_nettype none

module mcwdg_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_out_valid,
    input wire                  i_out_stall,
    input mcwdg_pkg::t_out_item i_out_data
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_data))
        else $error("result dropped or changed under stall");

    // a rejected transaction neither reloads nor hands out an id
    a_reject_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_data.status != mcwdg_pkg::STATUS_OK)
        |-> !i_out_data.reloaded && (i_out_data.new_id == '0) && !i_out_data.expired)
        else $error("rejected transaction had side effects");

    // expiry leaves the counter at zero
    a_expired_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.expired |-> (i_out_data.counter_value == '0)
        && !i_out_data.reloaded)
        else $error("expiry with non-zero counter");

    // the expiry report only comes with init, which never reloads
    a_report_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.reset_by_watchdog
        |-> (i_out_data.status == mcwdg_pkg::STATUS_OK) && !i_out_data.expired
        && !i_out_data.reloaded && (i_out_data.new_id == '0))
        else $error("expiry report mixed with other events");

endmodule

bind multi_client_watchdog mcwdg_checker u_mcwdg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);

`default_nettype wire
